// ===== sv/depth_first_search_engine_defines.svh =====
// assertion macros used by the checker file
`ifndef DEPTH_FIRST_SEARCH_ENGINE_DEFINES_SVH
`define DEPTH_FIRST_SEARCH_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DFSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define DFSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dfse_pkg.sv =====
// ----------------------------------------------------------------------------
// dfse_pkg
// shared types and constants of the depth-first search engine
// ----------------------------------------------------------------------------
package dfse_pkg;

    localparam int OP_W             = 2;
    localparam int VTX_W            = 4;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_EDGES    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_RUN      = 2'd2
    } op_t;

    typedef enum logic {
        RK_VISIT  = 1'b0,
        RK_REJECT = 1'b1
    } result_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_LIST,
        ST_ADD_LINK,
        ST_RUN_FIRST,
        ST_STEP,
        ST_ARC_WAIT,
        ST_POP_WAIT,
        ST_EMIT,
        ST_DESCEND,
        ST_FLUSH
    } state_t;

endpackage

// ===== sv/depth_first_search_engine.sv =====
// ----------------------------------------------------------------------------
// depth_first_search_engine
// directed graph held as per-vertex arc lists, walked depth-first on request
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one request per accepted handshake.
//     add edge appends edge_target to the list of edge_source; clear empties
//     all lists; run walks depth-first from start_vertex.
//   output channel (out_valid / out_stall): one result register. a run gives
//     one visit result per newly reached vertex in preorder, last_of_run set
//     on the final one; a full arc table gives one reject result.
// busy states
//   add edge: busy in ST_ADD_LIST, then ST_ADD_LINK if the source list has
//   arcs; a reject result is loaded as the request is taken. clear: never
//   leaves idle. run: ST_RUN_FIRST, then one read of the arc memory per arc
//   examined, and per vertex reached a list-memory read plus a stack pop later.
//   one request is worked on at a time; in_stall is high while busy.
// reset
//   asynchronous, active low: all lists empty, arc count zero, no result.
// stall
//   a stalled result holds; a run pauses before each new result until the
//   result register is free, so nothing is lost or dropped.
// ----------------------------------------------------------------------------
module depth_first_search_engine
    import dfse_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
)
(
    input  logic             clk,
    input  logic             rst_n,
    // request channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [OP_W-1:0]  operation,
    input  logic [VTX_W-1:0] edge_source,
    input  logic [VTX_W-1:0] edge_target,
    input  logic [VTX_W-1:0] start_vertex,
    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic             result_kind,
    output logic [VTX_W-1:0] visited_vertex,
    output logic             last_of_run
);

    // vertex index, arc pointer (null = MAX_EDGES), arc index, stack level
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = $clog2(MAX_EDGES + 1);
    localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LW = $clog2(MAX_VERTICES + 1);
    localparam logic [AW-1:0] ARC_NULL = AW'(MAX_EDGES);

    // memories
    logic [VTX_W-1:0] dest_mem  [MAX_EDGES];
    logic [AW-1:0]    succ_mem  [MAX_EDGES];
    logic [AW-1:0]    first_mem [MAX_VERTICES];
    logic [AW-1:0]    final_mem [MAX_VERTICES];
    logic [AW-1:0]    stack_mem [MAX_VERTICES];

    // control state
    state_t                  state_reg, state_next;
    logic [LW-1:0]           level_reg, level_next;
    logic [AW-1:0]           arc_count_reg, arc_count_next;
    logic [MAX_VERTICES-1:0] list_vld_reg, list_vld_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic                    out_valid_reg, out_valid_next;

    // datapath registers
    logic [AW-1:0]    top_reg, top_next;
    logic [VTX_W-1:0] vtx_reg, vtx_next;
    logic [VTX_W-1:0] pend_reg, pend_next;
    logic [VTX_W-1:0] src_reg, src_next;
    logic [AW-1:0]    link_reg, link_next;
    logic [AW-1:0]    new_arc_reg, new_arc_next;
    logic             kind_reg;
    logic [VTX_W-1:0] vout_reg;
    logic             last_reg;

    // memory read data
    logic [VTX_W-1:0] dest_rd_reg;
    logic [AW-1:0]    succ_rd_reg;
    logic [AW-1:0]    first_rd_reg;
    logic [AW-1:0]    final_rd_reg;
    logic             list_hit_reg;
    logic [AW-1:0]    stack_rd_reg;

    // memory control
    logic             list_we, arc_re, stack_re, stack_we, dest_we, succ_we;
    logic [VW-1:0]    list_ra, list_wa, stack_wa, stack_ra;
    logic [AW-1:0]    first_wd, final_wd, succ_wd;
    logic [IW-1:0]    succ_wa;

    // result load
    logic             out_load;
    logic             out_kind_d;
    logic [VTX_W-1:0] out_vtx_d;
    logic             out_last_d;

    logic             in_take, out_free;
    logic             src_ok, dst_ok, start_ok, dest_ok;
    logic [VW-1:0]    dest_idx;

    assign out_free = !out_valid_reg || !out_stall;
    assign src_ok   = 32'(edge_source)  < 32'(MAX_VERTICES);
    assign dst_ok   = 32'(edge_target)  < 32'(MAX_VERTICES);
    assign start_ok = 32'(start_vertex) < 32'(MAX_VERTICES);
    assign dest_ok  = 32'(dest_rd_reg)  < 32'(MAX_VERTICES);
    assign dest_idx = VW'(dest_rd_reg);

    // one request at a time; a reject needs the result register free
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        arc_count_next = arc_count_reg;
        list_vld_next  = list_vld_reg;
        visited_next   = visited_reg;
        out_valid_next = out_valid_reg && out_stall;
        top_next       = top_reg;
        vtx_next       = vtx_reg;
        pend_next      = pend_reg;
        src_next       = src_reg;
        link_next      = link_reg;
        new_arc_next   = new_arc_reg;

        out_load   = 1'b0;
        out_kind_d = RK_VISIT;
        out_vtx_d  = pend_reg;
        out_last_d = 1'b0;

        list_ra  = VW'(edge_source);
        list_we  = 1'b0;
        list_wa  = VW'(src_reg);
        first_wd = arc_count_reg;
        final_wd = arc_count_reg;
        dest_we  = 1'b0;
        succ_we  = 1'b0;
        succ_wa  = arc_count_reg[IW-1:0];
        succ_wd  = ARC_NULL;
        arc_re   = 1'b0;
        stack_re = 1'b0;
        stack_we = 1'b0;
        stack_wa = VW'(level_reg - LW'(1));
        stack_ra = VW'(level_reg - LW'(2));

        case (state_reg)
            ST_IDLE:
            begin
                if (operation == OP_RUN)
                begin
                    list_ra = VW'(start_vertex);
                end
                if (in_take)
                begin
                    case (operation)
                        OP_ADD_EDGE:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                if (arc_count_reg >= ARC_NULL)
                                begin
                                    // table full: drop edge, report it
                                    out_load       = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_kind_d     = RK_REJECT;
                                    out_vtx_d      = '0;
                                    out_last_d     = 1'b1;
                                end
                                else
                                begin
                                    dest_we    = 1'b1;
                                    src_next   = edge_source;
                                    state_next = ST_ADD_LIST;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            list_vld_next  = '0;
                            arc_count_next = '0;
                        end
                        OP_RUN:
                        begin
                            visited_next = '0;
                            level_next   = '0;
                            if (start_ok)
                            begin
                                visited_next[VW'(start_vertex)] = 1'b1;
                                pend_next  = start_vertex;
                                state_next = ST_RUN_FIRST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD_LIST:
            begin
                // append new arc at the tail of the source list
                list_we               = 1'b1;
                list_vld_next[list_wa] = 1'b1;
                succ_we               = 1'b1;
                new_arc_next          = arc_count_reg;
                arc_count_next        = arc_count_reg + AW'(1);
                if (list_hit_reg)
                begin
                    first_wd   = first_rd_reg;
                    link_next  = final_rd_reg;
                    state_next = ST_ADD_LINK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_LINK:
            begin
                succ_we    = 1'b1;
                succ_wa    = link_reg[IW-1:0];
                succ_wd    = new_arc_reg;
                state_next = ST_IDLE;
            end
            ST_RUN_FIRST:
            begin
                top_next   = list_hit_reg ? first_rd_reg : ARC_NULL;
                level_next = LW'(1);
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (top_reg == ARC_NULL)
                begin
                    if (level_reg == LW'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        stack_re   = 1'b1;
                        state_next = ST_POP_WAIT;
                    end
                end
                else
                begin
                    arc_re     = 1'b1;
                    state_next = ST_ARC_WAIT;
                end
            end
            ST_ARC_WAIT:
            begin
                top_next = succ_rd_reg;
                if (dest_ok && !visited_reg[dest_idx] &&
                    (level_reg < LW'(MAX_VERTICES)))
                begin
                    vtx_next   = dest_rd_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_POP_WAIT:
            begin
                top_next   = stack_rd_reg;
                level_next = level_reg - LW'(1);
                state_next = ST_STEP;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    pend_next      = vtx_reg;
                    visited_next[VW'(vtx_reg)] = 1'b1;
                    stack_we       = 1'b1;
                    list_ra        = VW'(vtx_reg);
                    state_next     = ST_DESCEND;
                end
            end
            ST_DESCEND:
            begin
                top_next   = list_hit_reg ? first_rd_reg : ARC_NULL;
                level_next = level_reg + LW'(1);
                state_next = ST_STEP;
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_last_d     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            arc_count_reg <= '0;
            list_vld_reg  <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            arc_count_reg <= arc_count_next;
            list_vld_reg  <= list_vld_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        vtx_reg     <= vtx_next;
        pend_reg    <= pend_next;
        src_reg     <= src_next;
        link_reg    <= link_next;
        new_arc_reg <= new_arc_next;
        if (out_load)
        begin
            kind_reg <= out_kind_d;
            vout_reg <= out_vtx_d;
            last_reg <= out_last_d;
        end
    end

    // arc memory: destination and successor pointer
    always_ff @(posedge clk)
    begin
        if (dest_we)
        begin
            dest_mem[arc_count_reg[IW-1:0]] <= edge_target;
        end
        if (succ_we)
        begin
            succ_mem[succ_wa] <= succ_wd;
        end
        if (arc_re)
        begin
            dest_rd_reg <= dest_mem[top_reg[IW-1:0]];
            succ_rd_reg <= succ_mem[top_reg[IW-1:0]];
        end
    end

    // list memory: head and tail arc per vertex, valid bits in flops
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            first_mem[list_wa] <= first_wd;
            final_mem[list_wa] <= final_wd;
        end
        first_rd_reg <= first_mem[list_ra];
        final_rd_reg <= final_mem[list_ra];
        list_hit_reg <= list_vld_reg[list_ra];
    end

    // walk stack: entries below the top, top lives in top_reg
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= top_reg;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_ra];
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign visited_vertex = vout_reg;
    assign last_of_run    = last_reg;

endmodule

// ===== sv/dfse_checker.sv =====
// ----------------------------------------------------------------------------
// dfse_checker
// port-level checks of the depth-first search engine, bound to the top level
// ----------------------------------------------------------------------------
`include "depth_first_search_engine_defines.svh"

module dfse_checker
    import dfse_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [OP_W-1:0]  operation,
    input logic [VTX_W-1:0] start_vertex,
    input logic             out_valid,
    input logic             out_stall,
    input logic             result_kind,
    input logic [VTX_W-1:0] visited_vertex,
    input logic             last_of_run
);

    // held result must not move
    `DFSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(visited_vertex) && $stable(last_of_run), "stalled result changed")

    // a reject is a single closing result with vertex zero
    `DFSE_ASSERT_SAME(a_reject_form, out_valid && (result_kind == RK_REJECT), (visited_vertex == '0) && last_of_run, "malformed reject result")

    // a run from a real vertex keeps the block busy
    `DFSE_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && (operation == OP_RUN) && (32'(start_vertex) < 32'(MAX_VERTICES)), in_stall, "run did not hold off requests")

    // clear produces no result
    `DFSE_ASSERT_NEXT(a_clear_quiet, in_valid && !in_stall && (operation == OP_CLEAR), !out_valid, "result after clear")

endmodule

bind depth_first_search_engine dfse_checker #(
    .MAX_VERTICES(MAX_VERTICES)
) u_dfse_checker (.*);

// ===== tb/depth_first_search_engine_tb.sv =====
// ----------------------------------------------------------------------------
// depth_first_search_engine_tb
// self-checking bench for the depth-first search engine
// ----------------------------------------------------------------------------
// requests (add edge, clear, run, unused code) are queued up front by a
// directed list and random graph-building phases. A negedge driver sends them
// in bursts with random gaps. A posedge monitor keeps its own copy of the arc
// table. On every accepted request it works out the preorder visit results
// (or the table-full reject) and checks each accepted result against the
// oldest expected one. The result side stalls in changing patterns.
// ----------------------------------------------------------------------------
module depth_first_search_engine_tb
    import dfse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // the unused operation code, ignored by the engine
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // null arc pointer in the shadow table
    localparam int ARC_NULL = DEF_MAX_EDGES;
    localparam int TAIL_CYCLES = 400;
    localparam int DRAIN_LIMIT = 200000;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
        logic [VTX_W-1:0] start;
        bit               drain_first;   // hold off until all results are in
    } graph_request_t;

    typedef struct {
        result_kind_t     kind;
        logic [VTX_W-1:0] vertex;
        logic             last;
    } visit_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  operation    = '0;
    logic [VTX_W-1:0] edge_source  = '0;
    logic [VTX_W-1:0] edge_target  = '0;
    logic [VTX_W-1:0] start_vertex = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic             result_kind;
    logic [VTX_W-1:0] visited_vertex;
    logic             last_of_run;

    // request queue filled at time zero, and results still owed by the engine
    graph_request_t pending_requests [$];
    visit_t         preorder_expected [$];

    // shadow copy of the arc table
    int arc_dest  [DEF_MAX_EDGES];
    int arc_link  [DEF_MAX_EDGES];
    int list_head [DEF_MAX_VERTICES];
    int list_tail [DEF_MAX_VERTICES];
    int arcs_used;

    int  mismatch_count = 0;
    bit  req_fire = 1'b0;       // the request on the bus was taken at the last posedge
    int  gap_left = 0;
    int  burst_left = 0;
    int  stall_mode = 0;
    int  stall_left = 0;

    depth_first_search_engine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .edge_source    (edge_source),
        .edge_target    (edge_target),
        .start_vertex   (start_vertex),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .visited_vertex (visited_vertex),
        .last_of_run    (last_of_run)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // shadow graph and preorder prediction
    // ------------------------------------------------------------------------
    task automatic lists_empty();
        foreach (list_head[k])
        begin
            list_head[k] = ARC_NULL;
            list_tail[k] = ARC_NULL;
        end
        arcs_used = 0;
    endtask

    task automatic graph_apply(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] src,
                               input logic [VTX_W-1:0] dst, input logic [VTX_W-1:0] start);
        int     a;
        int     t;
        int     depth;
        int     found;
        int     arc_stack [DEF_MAX_VERTICES];
        int     order [DEF_MAX_VERTICES];
        bit     seen [DEF_MAX_VERTICES];
        visit_t v;

        if (op == OP_ADD_EDGE)
        begin
            if (arcs_used >= DEF_MAX_EDGES)
            begin
                // table full: edge dropped, a lone reject result
                v.kind   = RK_REJECT;
                v.vertex = '0;
                v.last   = 1'b1;
                preorder_expected.push_back(v);
            end
            else
            begin
                arc_dest[arcs_used] = int'(dst);
                arc_link[arcs_used] = ARC_NULL;
                if (list_tail[src] != ARC_NULL)
                    arc_link[list_tail[src]] = arcs_used;
                else
                    list_head[src] = arcs_used;
                list_tail[src] = arcs_used;
                arcs_used++;
            end
        end
        else if (op == OP_CLEAR)
        begin
            lists_empty();
        end
        else if (op == OP_RUN)
        begin
            foreach (seen[k])
                seen[k] = 1'b0;
            seen[start]  = 1'b1;
            order[0]     = int'(start);
            found        = 1;
            arc_stack[0] = list_head[start];
            depth        = 1;
            // explicit stack of next-arc pointers, one level per vertex on the path
            while (depth > 0)
            begin
                a = arc_stack[depth-1];
                if (a == ARC_NULL)
                begin
                    depth--;
                end
                else
                begin
                    arc_stack[depth-1] = arc_link[a];
                    t = arc_dest[a];
                    if (!seen[t] && depth < DEF_MAX_VERTICES && found < DEF_MAX_VERTICES)
                    begin
                        seen[t]          = 1'b1;
                        order[found]     = t;
                        found++;
                        arc_stack[depth] = list_head[t];
                        depth++;
                    end
                end
            end
            for (int k = 0; k < found; k++)
            begin
                v.kind   = RK_VISIT;
                v.vertex = VTX_W'(order[k]);
                v.last   = (k == found - 1);
                preorder_expected.push_back(v);
            end
        end
        // unused code: nothing changes, nothing comes back
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_request(input logic [OP_W-1:0] op, input int src, input int dst,
                                 input int start, input bit drain_first);
        graph_request_t r;
        r.op          = op;
        r.src         = VTX_W'(src);
        r.dst         = VTX_W'(dst);
        r.start       = VTX_W'(start);
        r.drain_first = drain_first;
        pending_requests.push_back(r);
    endtask

    initial
    begin : stimulus
        int n_edges;
        int n_runs;
        int src;
        int dst;
        int wait_cycles;

        lists_empty();

        // directed: empty-graph runs at both extremes of the start vertex
        queue_request(OP_RUN, 3, 12, 0, 1'b0);
        queue_request(OP_RUN, 12, 3, 15, 1'b0);
        // extremes of source and target, a self loop and a duplicate edge
        queue_request(OP_ADD_EDGE, 0, 15, 9, 1'b0);
        queue_request(OP_ADD_EDGE, 15, 0, 6, 1'b0);
        queue_request(OP_ADD_EDGE, 0, 5, 0, 1'b0);
        queue_request(OP_ADD_EDGE, 5, 5, 15, 1'b0);
        queue_request(OP_ADD_EDGE, 0, 15, 0, 1'b0);
        queue_request(OP_ADD_EDGE, 5, 10, 7, 1'b0);
        queue_request(OP_ADD_EDGE, 10, 15, 8, 1'b0);
        queue_request(OP_RUN, 15, 15, 0, 1'b0);
        // unused code with every field at its top value
        queue_request(OP_UNUSED, 15, 15, 15, 1'b0);
        queue_request(OP_RUN, 0, 0, 15, 1'b0);
        queue_request(OP_RUN, 6, 9, 10, 1'b0);
        queue_request(OP_CLEAR, 10, 5, 6, 1'b0);
        // sender waits for the engine to drain before this one
        queue_request(OP_RUN, 9, 6, 0, 1'b1);
        queue_request(OP_UNUSED, 0, 0, 0, 1'b0);

        // random graph phases: build, walk a few times, usually clear
        while (pending_requests.size() < 420)
        begin
            if ($urandom_range(0, 9) == 0)
                n_edges = $urandom_range(60, 70);    // runs into the full table
            else
                n_edges = $urandom_range(0, 24);
            for (int k = 0; k < n_edges; k++)
            begin
                src = $urandom_range(0, 15);
                // chains half the time so that walks go deep
                if ($urandom_range(0, 1) == 0)
                    dst = (src + 1) % DEF_MAX_VERTICES;
                else
                    dst = $urandom_range(0, 15);
                queue_request(OP_ADD_EDGE, src, dst, $urandom_range(0, 15), 1'b0);
                if ($urandom_range(0, 19) == 0)
                    queue_request(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom_range(0, 15), 1'b0);
            end
            n_runs = $urandom_range(1, 4);
            for (int k = 0; k < n_runs; k++)
                queue_request(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 15), (k == 0) && ($urandom_range(0, 9) == 0));
            if ($urandom_range(0, 3) != 0)
                queue_request(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 15), 1'b0);
        end

        // reset once, released on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every request to be taken, then for the results
        while (pending_requests.size() != 0 || in_valid)
            @(posedge clk);
        wait_cycles = 0;
        while (preorder_expected.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        // watch a while longer for stray results
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && preorder_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // request driver: bursts of requests with random gaps, changes on negedge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        graph_request_t r;
        logic           next_valid;

        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !req_fire))
        begin
            // bus is free: the last request was taken or none was up
            next_valid = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].drain_first && preorder_expected.size() != 0))
            begin
                r = pending_requests.pop_front();
                operation    <= r.op;
                edge_source  <= r.src;
                edge_target  <= r.dst;
                start_vertex <= r.start;
                next_valid   = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // new burst; sometimes a long stretch with no gaps at all
                    if ($urandom_range(0, 4) == 0)
                    begin
                        gap_left   = 0;
                        burst_left = $urandom_range(20, 40);
                    end
                    else
                    begin
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 30)
                                                                 : $urandom_range(0, 3);
                        burst_left = $urandom_range(0, 10);
                    end
                end
            end
            in_valid <= next_valid;
        end
        // otherwise the stalled request holds unchanged
    end

    // ------------------------------------------------------------------------
    // result stall pattern: free-running, short random, or mostly stalled
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // monitor: checks results, predicts on accepted requests
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        visit_t want;

        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (preorder_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: kind %0d vertex %0d last %0d",
                                 result_kind, visited_vertex, last_of_run);
                end
                else
                begin
                    want = preorder_expected.pop_front();
                    if (result_kind !== want.kind || visited_vertex !== want.vertex ||
                        last_of_run !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.kind, want.vertex, want.last,
                                     result_kind, visited_vertex, last_of_run);
                    end
                end
            end
            // results of a request can only appear after it is taken
            if (in_valid && !in_stall)
                graph_apply(operation, edge_source, edge_target, start_vertex);
        end
        req_fire <= rst_n && in_valid && !in_stall;
    end

    // runaway guard
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
